[hdl/gde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gde_pkg
// Shared types, constants and the metadata table for device enumeration.
// ----------------------------------------------------------------------------
package gde_pkg;

  localparam int METADATA_LEN = 182;
  localparam int CHUNK_MAX    = 58;
  localparam int PACKET_MAX   = 64;

  localparam logic [7:0] CMD_ACK      = 8'h01;
  localparam logic [7:0] CMD_HELLO    = 8'h02;
  localparam logic [7:0] CMD_META     = 8'h04;
  localparam logic [7:0] CMD_START    = 8'h05;
  localparam logic [7:0] FLG_FIRST    = 8'hf0;
  localparam logic [7:0] FLG_CHUNK    = 8'ha0;
  localparam logic [7:0] FLG_LASTBIT  = 8'h10;
  localparam logic [7:0] FLG_SYSTEM   = 8'h20;

  localparam logic [7:0] META_LEN_B   = 8'(METADATA_LEN);
  localparam logic [5:0] CHUNK_MAX_B  = 6'(CHUNK_MAX);

  // configuration register indexes (byte address = index * 4)
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_VID      = 2'd1;
  localparam logic [1:0] REG_PID      = 2'd2;

  typedef enum logic [1:0] {
    ACT_RX    = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_RESET = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PS_ARRIVAL  = 2'd0,
    PS_METADATA = 2'd1,
    PS_IDLE     = 2'd2,
    PS_ACTIVE   = 2'd3
  } proto_t;

  typedef enum logic [2:0] {
    MP_NONE       = 3'd0,
    MP_SEND_FIRST = 3'd1,
    MP_WAIT_FIRST = 3'd2,
    MP_SEND_REST  = 3'd3,
    MP_WAIT_FINAL = 3'd4,
    MP_SEND_DONE  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    PK_HELLO = 2'd0,
    PK_ACK   = 2'd1,
    PK_CHUNK = 2'd2
  } pkind_t;

  // One outgoing packet: ack uses hflags/cmd/size, chunk uses hflags/where/start/count.
  typedef struct packed {
    pkind_t     kind;
    proto_t     link_state;
    logic [7:0] seq;
    logic [7:0] hflags;
    logic [7:0] cmd;
    logic [7:0] size;
    logic [7:0] where;
    logic [7:0] start;
    logic [5:0] count;
    logic [6:0] len;
  } desc_t;

  localparam logic [7:0] META_ROM [0:METADATA_LEN-1] = '{
    8'h10, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hb6, 8'h00,
    8'h77, 8'h00, 8'h16, 8'h00, 8'h1b, 8'h00, 8'h1c, 8'h00,
    8'h23, 8'h00, 8'h29, 8'h00, 8'h46, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h01, 8'h02, 8'h03,
    8'h04, 8'h06, 8'h07, 8'h05, 8'h01, 8'h04, 8'h05, 8'h06,
    8'h0a, 8'h01, 8'h1a, 8'h00, 8'h57, 8'h69, 8'h6e, 8'h64,
    8'h6f, 8'h77, 8'h73, 8'h2e, 8'h58, 8'h62, 8'h6f, 8'h78,
    8'h2e, 8'h49, 8'h6e, 8'h70, 8'h75, 8'h74, 8'h2e, 8'h47,
    8'h61, 8'h6d, 8'h65, 8'h70, 8'h61, 8'h64, 8'h03, 8'h56,
    8'hff, 8'h76, 8'h97, 8'hfd, 8'h9b, 8'h81, 8'h45, 8'had,
    8'h45, 8'hb6, 8'h45, 8'hbb, 8'ha5, 8'h26, 8'hd6, 8'h2c,
    8'h40, 8'h2e, 8'h08, 8'hdf, 8'h07, 8'he1, 8'h45, 8'ha5,
    8'hab, 8'ha3, 8'h12, 8'h7a, 8'hf1, 8'h97, 8'hb5, 8'he7,
    8'h1f, 8'hf3, 8'hb8, 8'h86, 8'h73, 8'he9, 8'h40, 8'ha9,
    8'hf8, 8'h2f, 8'h21, 8'h26, 8'h3a, 8'hcf, 8'hb7, 8'h02,
    8'h17, 8'h00, 8'h20, 8'h0e, 8'h00, 8'h01, 8'h00, 8'h10,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h17,
    8'h00, 8'h09, 8'h09, 8'h00, 8'h01, 8'h00, 8'h08, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] rom_rd(input logic [7:0] a);
    rom_rd = (a < META_LEN_B) ? META_ROM[a] : 8'h00;
  endfunction

  // Advance the sequence number, skipping zero on wrap.
  function automatic logic [7:0] bump(input logic [7:0] s);
    bump = (s == 8'hff) ? 8'h01 : s + 8'h01;
  endfunction

endpackage

[hdl/gde_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gde_fifo
// Two-entry descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module gde_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  gde_pkg::desc_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output gde_pkg::desc_t rd_data,
  output logic           empty
);
  import gde_pkg::*;

  desc_t      mem_r [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

[hdl/gde_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gde_front
// Protocol state and item classification; emits one descriptor per packet.
// ----------------------------------------------------------------------------
module gde_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic [1:0]     action,
  input  logic [6:0]     pkt_len,
  input  logic [7:0]     pkt_cmd,
  input  logic [7:0]     pkt_flags,
  input  logic [7:0]     pkt_size_byte,
  input  logic [7:0]     pkt_byte4,
  input  logic [7:0]     pkt_byte5,
  input  logic [31:0]    ack_offset,
  input  logic [15:0]    ack_remaining,
  input  logic [62:0]    now_us,
  input  logic           link_ready,
  input  logic [31:0]    hello_interval,
  output logic           d_push,
  output gde_pkg::desc_t d_out
);
  import gde_pkg::*;

  proto_t      ps_r, ps_nxt;
  phase_t      mp_r, mp_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [62:0] last_r, last_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [7:0]  mseq_r, mseq_nxt;
  logic        aw_r, aw_nxt;
  logic        send;
  desc_t       d;
  logic [7:0]  rem;
  logic [5:0]  cnt;
  logic [62:0] gap;
  logic        due;

  always_comb begin
    rem = META_LEN_B - off_r;
    cnt = (rem > {2'b00, CHUNK_MAX_B}) ? CHUNK_MAX_B : rem[5:0];
    gap = now_us - last_r;
    due = (last_r == '0) || ((now_us >= last_r) && (gap >= {31'd0, hello_interval}));

    ps_nxt   = ps_r;
    mp_nxt   = mp_r;
    seq_nxt  = seq_r;
    last_nxt = last_r;
    off_nxt  = off_r;
    mseq_nxt = mseq_r;
    aw_nxt   = aw_r;
    send     = 1'b0;
    d        = '0;

    case (action_t'(action))
      ACT_RX: begin
        if (pkt_len >= 7'd4) begin
          if (pkt_cmd == CMD_ACK) begin
            if (pkt_len >= 7'd13 && pkt_byte4 == 8'h00 && pkt_byte5 == CMD_META) begin
              if (mp_r == MP_WAIT_FIRST && ack_offset >= {24'd0, off_r}) begin
                mp_nxt = MP_SEND_REST;
              end else if (mp_r == MP_WAIT_FINAL && ack_offset >= 32'(METADATA_LEN)
                           && ack_remaining == 16'd0) begin
                mp_nxt = MP_SEND_DONE;
              end
            end
          end else if (pkt_cmd == CMD_META) begin
            if (mp_r == MP_NONE) begin
              aw_nxt   = 1'b0;
              off_nxt  = 8'd0;
              seq_nxt  = bump(seq_r);
              mseq_nxt = seq_nxt;
              mp_nxt   = MP_SEND_FIRST;
              ps_nxt   = PS_METADATA;
            end
          end else if (pkt_cmd == CMD_START) begin
            aw_nxt = 1'b1;
            if (mp_r == MP_NONE) ps_nxt = PS_ACTIVE;
          end
          if (pkt_flags[4]) begin
            seq_nxt = bump(seq_nxt);
            if (link_ready) begin
              send     = 1'b1;
              d.kind   = PK_ACK;
              d.seq    = seq_nxt;
              d.cmd    = pkt_cmd;
              d.hflags = pkt_flags & 8'hf0;
              d.size   = pkt_size_byte;
              d.len    = 7'd13;
            end
          end
        end
      end
      ACT_POLL: begin
        if (link_ready) begin
          if (mp_r == MP_SEND_FIRST || mp_r == MP_SEND_REST) begin
            send    = 1'b1;
            d.kind  = PK_CHUNK;
            d.seq   = mseq_r;
            d.start = off_r;
            d.count = cnt;
            d.len   = 7'd6 + {1'b0, cnt};
            off_nxt = off_r + {2'b00, cnt};
            if (mp_r == MP_SEND_FIRST) begin
              d.hflags = FLG_FIRST;
              d.where  = META_LEN_B;
              mp_nxt   = MP_WAIT_FIRST;
            end else begin
              d.hflags = (rem <= {2'b00, CHUNK_MAX_B}) ? (FLG_CHUNK | FLG_LASTBIT) : FLG_CHUNK;
              d.where  = off_r;
              mp_nxt   = (off_nxt >= META_LEN_B) ? MP_WAIT_FINAL : MP_SEND_REST;
            end
          end else if (mp_r == MP_SEND_DONE) begin
            send     = 1'b1;
            d.kind   = PK_CHUNK;
            d.seq    = mseq_r;
            d.hflags = FLG_CHUNK;
            d.where  = META_LEN_B;
            d.len    = 7'd6;
            mp_nxt   = MP_NONE;
            ps_nxt   = aw_r ? PS_ACTIVE : PS_IDLE;
          end else if (ps_r == PS_ARRIVAL && due) begin
            send     = 1'b1;
            seq_nxt  = bump(seq_r);
            d.kind   = PK_HELLO;
            d.seq    = seq_nxt;
            d.len    = 7'd32;
            last_nxt = now_us;
          end
        end
      end
      ACT_RESET: begin
        ps_nxt   = PS_ARRIVAL;
        mp_nxt   = MP_NONE;
        seq_nxt  = 8'd0;
        last_nxt = '0;
        off_nxt  = 8'd0;
        mseq_nxt = 8'd0;
        aw_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
    d.link_state = ps_nxt;
  end

  assign d_push = acc && send;
  assign d_out  = d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r   <= PS_ARRIVAL;
      mp_r   <= MP_NONE;
      seq_r  <= 8'd0;
      last_r <= '0;
      off_r  <= 8'd0;
      mseq_r <= 8'd0;
      aw_r   <= 1'b0;
    end else if (acc) begin
      ps_r   <= ps_nxt;
      mp_r   <= mp_nxt;
      seq_r  <= seq_nxt;
      last_r <= last_nxt;
      off_r  <= off_nxt;
      mseq_r <= mseq_nxt;
      aw_r   <= aw_nxt;
    end
  end
endmodule

[hdl/gde_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gde_back
// Packet serialiser: walks a descriptor one byte per cycle into the output while the output slot is free.
// ----------------------------------------------------------------------------
module gde_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  gde_pkg::desc_t q_data,
  output logic           q_pop,
  input  logic [15:0]    vendor_id,
  input  logic [15:0]    product_id,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic [1:0]     out_link_state,
  output logic           empty,
  input  logic           pop
);
  import gde_pkg::*;

  desc_t      desc_r;
  logic       busy_r;
  logic [5:0] idx_r;
  logic       ov_r;
  logic [7:0] ob_r;
  logic       ol_r;
  logic [1:0] os_r;
  logic       slot_free, emit, fin;
  logic [7:0] b;
  logic [5:0] di;

  assign slot_free = !ov_r || pop;
  assign emit      = busy_r && slot_free;
  assign fin       = ({1'b0, idx_r} + 7'd1) == desc_r.len;
  assign q_pop     = !busy_r && !q_empty;

  always_comb begin
    di = idx_r - 6'd6;
    b  = 8'h00;
    case (desc_r.kind)
      PK_HELLO: begin
        case (idx_r)
          6'd0:  b = CMD_HELLO;
          6'd1:  b = FLG_SYSTEM;
          6'd2:  b = desc_r.seq;
          6'd3:  b = 8'd28;
          6'd4:  b = 8'he2;
          6'd5:  b = 8'h17;
          6'd6:  b = 8'h05;
          6'd7:  b = 8'h11;
          6'd8:  b = 8'h0b;
          6'd12: b = vendor_id[7:0];
          6'd13: b = vendor_id[15:8];
          6'd14: b = product_id[7:0];
          6'd15: b = product_id[15:8];
          6'd16: b = 8'h01;
          6'd24: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      PK_ACK: begin
        case (idx_r)
          6'd0:  b = CMD_ACK;
          6'd1:  b = FLG_SYSTEM;
          6'd2:  b = desc_r.seq;
          6'd3:  b = 8'd9;
          6'd5:  b = desc_r.cmd;
          6'd6:  b = desc_r.hflags;
          6'd7:  b = desc_r.size;
          default: b = 8'h00;
        endcase
      end
      PK_CHUNK: begin
        // one-byte offset needs a pad byte to land the data on an even position
        case (idx_r)
          6'd0: b = CMD_META;
          6'd1: b = desc_r.hflags;
          6'd2: b = desc_r.seq;
          6'd3: b = desc_r.where[7] ? {2'b00, desc_r.count} : {2'b10, desc_r.count};
          6'd4: b = desc_r.where[7] ? (desc_r.where | 8'h80) : 8'h00;
          6'd5: b = desc_r.where[7] ? 8'h01 : desc_r.where;
          default: b = rom_rd(desc_r.start + {2'b00, di});
        endcase
      end
      default: b = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) desc_r <= q_data;
    if (emit) begin
      ob_r <= b;
      ol_r <= fin;
      os_r <= desc_r.link_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 6'd0;
      ov_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= 6'd0;
      end else if (emit) begin
        idx_r <= idx_r + 6'd1;
        if (fin) busy_r <= 1'b0;
      end
      if (emit) ov_r <= 1'b1;
      else if (pop) ov_r <= 1'b0;
    end
  end

  assign empty          = !ov_r;
  assign out_byte       = ob_r;
  assign out_last       = ol_r;
  assign out_link_state = os_r;
endmodule

[hdl/gip_device_enumeration.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gip_device_enumeration
// Device side of the enumeration handshake: hello, metadata chunks and acks.
// ----------------------------------------------------------------------------
// Each accepted item updates the protocol state in the same cycle and, if it
// calls for a packet, queues a descriptor; the serialiser then transfers the
// packet one byte per cycle while the output is not stalled (6 to 64 bytes
// for chunks, 13 for an ack, 32 for a hello). The two-entry descriptor queue
// lets the front accept up to two packets ahead of the serialiser.
// Configuration sits on an APB-style port: hello interval at 0x0, vendor id
// at 0x4, product id at 0x8.
module gip_device_enumeration (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_pkt_len,
  input  logic [7:0]  in_pkt_cmd,
  input  logic [7:0]  in_pkt_flags,
  input  logic [7:0]  in_pkt_size_byte,
  input  logic [7:0]  in_pkt_byte4,
  input  logic [7:0]  in_pkt_byte5,
  input  logic [31:0] in_ack_offset,
  input  logic [15:0] in_ack_remaining,
  input  logic [62:0] in_now_us,
  input  logic        in_link_ready,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [1:0]  out_link_state,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gde_pkg::*;

  logic [31:0] interval_r;
  logic [15:0] vid_r, pid_r;
  logic        acc, d_push, q_empty, q_pop;
  desc_t       d_in, q_data;

  assign pready = 1'b1;
  assign acc    = push && !full;

  // register file: write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 32'd500000;
      vid_r      <= 16'd0;
      pid_r      <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_INTERVAL: interval_r <= pwdata;
        REG_VID:      vid_r      <= pwdata[15:0];
        REG_PID:      pid_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INTERVAL: prdata = interval_r;
      REG_VID:      prdata = {16'd0, vid_r};
      REG_PID:      prdata = {16'd0, pid_r};
      default:      prdata = 32'd0;
    endcase
  end

  gde_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc),
    .action(in_action), .pkt_len(in_pkt_len), .pkt_cmd(in_pkt_cmd),
    .pkt_flags(in_pkt_flags), .pkt_size_byte(in_pkt_size_byte),
    .pkt_byte4(in_pkt_byte4), .pkt_byte5(in_pkt_byte5),
    .ack_offset(in_ack_offset), .ack_remaining(in_ack_remaining),
    .now_us(in_now_us), .link_ready(in_link_ready),
    .hello_interval(interval_r), .d_push(d_push), .d_out(d_in)
  );

  // hold new items off while the queue cannot take a descriptor
  gde_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(d_push), .wr_data(d_in), .full(full),
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  gde_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .vendor_id(vid_r), .product_id(pid_r),
    .out_byte(out_byte), .out_last(out_last), .out_link_state(out_link_state),
    .empty(empty), .pop(pop)
  );
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the device enumeration block: a clocked driver
// feeds queued items, a clocked monitor pops packet bytes and compares them
// against a local model of hello pacing, metadata chunking and acks.
// ----------------------------------------------------------------------------
module tb;
  import gde_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct {
    bit [1:0]  action;
    bit [6:0]  pkt_len;
    bit [7:0]  pkt_cmd;
    bit [7:0]  pkt_flags;
    bit [7:0]  pkt_size_byte;
    bit [7:0]  pkt_byte4;
    bit [7:0]  pkt_byte5;
    bit [31:0] ack_offset;
    bit [15:0] ack_remaining;
    bit [62:0] now_us;
    bit        link_ready;
  } item_t;

  typedef struct {
    bit [7:0] data;
    bit       last;
    bit [1:0] lstate;
  } txbyte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [1:0]  out_link_state;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  item_t       drv = '{default: 0};

  item_t   pending[$];
  txbyte_t tx_expected[$];
  int      errors = 0;
  bit      calm = 1'b0;
  int      in_gap = 0, out_stall = 0, quiet = 0;

  // Model of the block's configuration and protocol state
  bit [31:0] m_interval;
  bit [15:0] m_vid, m_pid;
  proto_t    m_proto;
  phase_t    m_phase;
  bit [7:0]  m_seq, m_off, m_mseq;
  bit [63:0] m_last_hello;
  bit        m_active;
  bit [7:0]  pkt[PACKET_MAX];
  int        plen;
  bit [62:0] tb_now;

  always #6 clk = ~clk;

  gip_device_enumeration u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_action(drv.action), .in_pkt_len(drv.pkt_len), .in_pkt_cmd(drv.pkt_cmd),
    .in_pkt_flags(drv.pkt_flags), .in_pkt_size_byte(drv.pkt_size_byte),
    .in_pkt_byte4(drv.pkt_byte4), .in_pkt_byte5(drv.pkt_byte5),
    .in_ack_offset(drv.ack_offset), .in_ack_remaining(drv.ack_remaining),
    .in_now_us(drv.now_us), .in_link_ready(drv.link_ready),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_last(out_last),
    .out_link_state(out_link_state),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic void to_arrival();
    m_proto = PS_ARRIVAL;
    m_phase = MP_NONE;
    m_seq = 0;
    m_last_hello = 0;
    m_off = 0;
    m_mseq = 0;
    m_active = 0;
  endfunction

  function automatic bit [7:0] next_seq();
    m_seq = (m_seq == 8'hff) ? 8'h01 : m_seq + 8'h01;
    return m_seq;
  endfunction

  // Assemble a metadata chunk; return 0 if it would overflow a packet.
  function automatic bit make_chunk(bit [7:0] flags, bit [7:0] sq, bit [31:0] where,
                                    bit [7:0] start, int count);
    bit [7:0]  vb[3];
    int        vn, hdr, idx;
    bit [15:0] v;
    bit [7:0]  b;
    vn = 0;
    hdr = 4;
    v = where[15:0];
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      vb[vn] = b;
      vn++;
    end while (v != 0 && vn < 3);
    // pad so that the data begins on an even byte
    if (((hdr + vn) & 1) != 0) hdr = 5;
    if (hdr + vn + count > PACKET_MAX) return 0;
    pkt[0] = CMD_META;
    pkt[1] = flags;
    pkt[2] = sq;
    pkt[3] = (hdr == 5) ? (8'(count) | 8'h80) : 8'(count);
    if (hdr == 5) pkt[4] = 8'h00;
    for (int i = 0; i < vn; i++) pkt[hdr + i] = vb[i];
    hdr += vn;
    for (int i = 0; i < count; i++) begin
      idx = (start + i) & 8'hff;
      pkt[hdr + i] = (idx < METADATA_LEN) ? META_ROM[idx] : 8'h00;
    end
    plen = hdr + count;
    return 1;
  endfunction

  function automatic void send_chunk(bit first);
    int       remaining, count;
    bit [7:0] flags;
    remaining = METADATA_LEN - m_off;
    count = (remaining > CHUNK_MAX) ? CHUNK_MAX : remaining;
    flags = first ? FLG_FIRST : FLG_CHUNK;
    if (!first && remaining <= CHUNK_MAX) flags |= FLG_LASTBIT;
    if (!make_chunk(flags, m_mseq, first ? METADATA_LEN : m_off, m_off, count)) return;
    m_off = 8'(m_off + count);
    if (first) m_phase = MP_WAIT_FIRST;
    else if (m_off >= METADATA_LEN) m_phase = MP_WAIT_FINAL;
    else m_phase = MP_SEND_REST;
  endfunction

  function automatic void send_hello(bit [62:0] now);
    // a clock running backwards is never due
    if (m_last_hello != 0 &&
        ({1'b0, now} < m_last_hello || {1'b0, now} - m_last_hello < {32'd0, m_interval}))
      return;
    for (int i = 0; i < 32; i++) pkt[i] = 8'h00;
    pkt[0] = CMD_HELLO;
    pkt[1] = FLG_SYSTEM;
    pkt[2] = next_seq();
    pkt[3] = 8'd28;
    pkt[4] = 8'he2; pkt[5] = 8'h17; pkt[6] = 8'h05;
    pkt[7] = 8'h11; pkt[8] = 8'h0b;
    pkt[12] = m_vid[7:0];  pkt[13] = m_vid[15:8];
    pkt[14] = m_pid[7:0];  pkt[15] = m_pid[15:8];
    pkt[16] = 8'h01;
    pkt[24] = 8'h01;
    plen = 32;
    m_last_hello = {1'b0, now};
  endfunction

  function automatic void take_host_packet(item_t it);
    bit [7:0] sq;
    if (it.pkt_len < 4) return;
    if (it.pkt_cmd == CMD_ACK) begin
      if (it.pkt_len >= 13 && it.pkt_byte4 == 0 && it.pkt_byte5 == CMD_META) begin
        if (m_phase == MP_WAIT_FIRST && it.ack_offset >= m_off) m_phase = MP_SEND_REST;
        else if (m_phase == MP_WAIT_FINAL && it.ack_offset >= METADATA_LEN &&
                 it.ack_remaining == 0) m_phase = MP_SEND_DONE;
      end
    end else if (it.pkt_cmd == CMD_META) begin
      if (m_phase == MP_NONE) begin
        m_active = 0;
        m_off = 0;
        m_mseq = next_seq();
        m_phase = MP_SEND_FIRST;
        m_proto = PS_METADATA;
      end
    end else if (it.pkt_cmd == CMD_START) begin
      m_active = 1;
      if (m_phase == MP_NONE) m_proto = PS_ACTIVE;
    end
    if ((it.pkt_flags & FLG_LASTBIT) == 0) return;
    sq = next_seq();
    if (!it.link_ready) return;
    for (int i = 0; i < 13; i++) pkt[i] = 8'h00;
    pkt[0] = CMD_ACK;
    pkt[1] = FLG_SYSTEM;
    pkt[2] = sq;
    pkt[3] = 8'd9;
    pkt[5] = it.pkt_cmd;
    pkt[6] = it.pkt_flags & 8'hf0;
    pkt[7] = it.pkt_size_byte;
    plen = 13;
  endfunction

  // Advance the model by one item and queue the bytes it transmits.
  function automatic void predict_packet(item_t it);
    txbyte_t t;
    plen = 0;
    case (action_t'(it.action))
      ACT_RX: take_host_packet(it);
      ACT_POLL: begin
        if (it.link_ready) begin
          if (m_phase == MP_SEND_FIRST) send_chunk(1);
          else if (m_phase == MP_SEND_REST) send_chunk(0);
          else if (m_phase == MP_SEND_DONE) begin
            if (make_chunk(FLG_CHUNK, m_mseq, METADATA_LEN, 0, 0)) begin
              m_phase = MP_NONE;
              m_proto = m_active ? PS_ACTIVE : PS_IDLE;
            end
          end else if (m_proto == PS_ARRIVAL) send_hello(it.now_us);
        end
      end
      ACT_RESET: to_arrival();
      default: ;
    endcase
    for (int k = 0; k < plen; k++) begin
      t.data = pkt[k];
      t.last = (k + 1 == plen);
      t.lstate = m_proto;
      tx_expected.push_back(t);
    end
  endfunction

  task automatic report_miss(string what, int got, int want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: one transfer per accepted item, random idle bursts between items
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit    nxt_push;
    item_t nxt;
    nxt_push = push;
    nxt = drv;
    if (rst_n) begin
      if (push && !full) begin
        predict_packet(drv);
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 6) - 1;
        end else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          nxt_push = 1'b1;
        end
      end
    end
    push <= nxt_push;
    drv <= nxt;
  end

  // --------------------------------------------------------------------------
  // Monitor: check each popped byte against the oldest expected one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    txbyte_t e;
    bit      nxt_pop;
    nxt_pop = 1'b0;
    if (rst_n) begin
      if (pop && !empty) begin
        if (tx_expected.size() == 0) begin
          report_miss("unexpected byte", out_byte, 0);
        end else begin
          e = tx_expected.pop_front();
          if (out_byte !== e.data) report_miss("out_byte", out_byte, e.data);
          if (out_last !== e.last) report_miss("out_last", out_last, e.last);
          if (out_link_state !== e.lstate)
            report_miss("out_link_state", out_link_state, e.lstate);
        end
      end
      // stall in bursts, never in the closing stretch
      if (out_stall > 0) begin
        out_stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(1, 6) - 1;
      end else begin
        nxt_pop = 1'b1;
      end
    end
    pop <= nxt_pop;
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("[gip_device_enumeration] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic item_t rand_item();
    item_t it;
    it.action = 2'($urandom_range(0, 3));
    it.pkt_len = 7'($urandom_range(0, 127));
    it.pkt_cmd = 8'($urandom);
    it.pkt_flags = 8'($urandom);
    it.pkt_size_byte = 8'($urandom);
    it.pkt_byte4 = 8'($urandom);
    it.pkt_byte5 = 8'($urandom);
    it.ack_offset = $urandom;
    it.ack_remaining = 16'($urandom);
    it.now_us = 63'({$urandom, $urandom});
    it.link_ready = 1'($urandom);
    return it;
  endfunction

  task automatic add_rx(bit [7:0] cmd, bit [7:0] flags, bit [6:0] len, bit ready);
    item_t it;
    it = rand_item();
    it.action = ACT_RX;
    it.pkt_cmd = cmd;
    it.pkt_flags = flags;
    it.pkt_len = len;
    it.link_ready = ready;
    pending.push_back(it);
  endtask

  task automatic add_ack(bit [31:0] off, bit [15:0] rem);
    item_t it;
    it = rand_item();
    it.action = ACT_RX;
    it.pkt_cmd = CMD_ACK;
    it.pkt_len = 7'($urandom_range(13, 64));
    it.pkt_byte4 = 8'h00;
    it.pkt_byte5 = CMD_META;
    it.ack_offset = off;
    it.ack_remaining = rem;
    pending.push_back(it);
  endtask

  task automatic add_poll(bit [62:0] now, bit ready);
    item_t it;
    it = rand_item();
    it.action = ACT_POLL;
    it.now_us = now;
    it.link_ready = ready;
    pending.push_back(it);
  endtask

  task automatic add_reset();
    item_t it;
    it = rand_item();
    it.action = ACT_RESET;
    pending.push_back(it);
  endtask

  // A mostly well-formed enumeration with random detours
  task automatic add_enumeration();
    add_rx(CMD_META, 8'($urandom), 7'($urandom_range(4, 64)), 1'($urandom));
    if ($urandom_range(0, 3) == 0) add_rx(CMD_META, 8'h00, 7'd8, 1'b1);
    for (int c = 0; c < 4; c++) begin
      if ($urandom_range(0, 5) == 0) add_poll(tb_now, 1'b0);
      add_poll(tb_now, 1'b1);
      if ($urandom_range(0, 5) == 0) add_rx(CMD_START, 8'($urandom), 7'd4, 1'b1);
      if (c < 3) add_ack($urandom_range(58, 400), ($urandom_range(0, 1)) ? 16'($urandom) : 16'h0);
      else add_ack(($urandom_range(0, 7) == 0) ? 32'($urandom) : $urandom_range(182, 300),
                   ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0);
    end
    add_poll(tb_now, 1'b1);
  endtask

  function automatic int m_interval_guess();
    return (m_interval > 32'd100000) ? 100000 : int'(m_interval) + 1;
  endfunction

  task automatic add_noise();
    item_t it;
    int    r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      tb_now = tb_now + 63'($urandom_range(0, 2 * m_interval_guess()));
      add_poll(tb_now, $urandom_range(0, 4) != 0);
    end else begin
      it = rand_item();
      pending.push_back(it);
    end
  endtask

  // Sample on the falling edge so that a transfer taken at the rising edge is seen.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending.size() != 0 || push || tx_expected.size() != 0 || !empty);
  endtask

  task automatic wait_quiet();
    wait_drained();
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(bit [1:0] idx, bit [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge
    case (idx)
      REG_INTERVAL: m_interval = data;
      REG_VID:      m_vid = data[15:0];
      REG_PID:      m_pid = data[15:0];
      default: ;
    endcase
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic run_phase(int n);
    int start;
    start = pending.size();
    while (pending.size() - start < n) begin
      if ($urandom_range(0, 9) < 6) add_enumeration();
      else if ($urandom_range(0, 7) == 0) add_reset();
      else add_noise();
    end
  endtask

  initial begin
    m_interval = 32'd500000;
    m_vid = 0;
    m_pid = 0;
    to_arrival();
    tb_now = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pacing, short packet, ack request, unused action, one enumeration
    add_poll(63'd0, 1'b1);
    add_poll(63'd100, 1'b1);
    add_poll(63'd600000, 1'b1);
    add_poll(63'd5, 1'b1);
    add_poll(63'd2000000, 1'b0);
    add_rx(8'h33, 8'h10, 7'd3, 1'b1);
    add_rx(8'hff, 8'hff, 7'd127, 1'b0);
    add_rx(8'h00, 8'h10, 7'd4, 1'b1);
    begin
      item_t it;
      it = rand_item();
      it.action = ACT_NONE;
      pending.push_back(it);
      it = rand_item();
      it.action = ACT_POLL;
      it.now_us = '1;
      it.link_ready = 1'b1;
      pending.push_back(it);
    end
    add_rx(CMD_META, 8'h10, 7'd64, 1'b1);
    add_rx(CMD_META, 8'h00, 7'd4, 1'b1);
    add_poll(63'd0, 1'b1);
    add_ack(32'd10, 16'd0);
    add_ack(32'hffffffff, 16'hffff);
    add_poll(63'd0, 1'b1);
    add_ack(32'd200, 16'd0);
    add_poll(63'd0, 1'b1);
    add_ack(32'd200, 16'd0);
    add_poll(63'd0, 1'b1);
    add_ack(32'd181, 16'd0);
    add_ack(32'd182, 16'd0);
    add_rx(CMD_START, 8'h10, 7'd4, 1'b1);
    add_poll(63'd0, 1'b1);
    add_reset();
    add_rx(CMD_START, 8'h00, 7'd4, 1'b1);
    // hold the sender until everything has drained
    wait_quiet();

    cfg_write(REG_INTERVAL, 32'd0);
    cfg_write(REG_VID, 32'hffff);
    cfg_write(REG_PID, 32'h0000);
    add_reset();
    run_phase(60);
    wait_quiet();

    cfg_write(REG_INTERVAL, 32'hffffffff);
    cfg_write(REG_VID, 32'h0000);
    cfg_write(REG_PID, 32'hffff);
    add_reset();
    run_phase(60);
    wait_quiet();

    cfg_write(REG_INTERVAL, $urandom_range(1, 5000));
    cfg_write(REG_VID, $urandom);
    cfg_write(REG_PID, $urandom);
    add_reset();
    run_phase(60);
    wait_quiet();

    cfg_write(REG_INTERVAL, 32'd1000);
    cfg_write(REG_VID, $urandom);
    cfg_write(REG_PID, $urandom);
    calm = 1'b1;
    run_phase(60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && tx_expected.size() == 0) begin
      $display("[gip_device_enumeration] OK");
    end else begin
      $display("[gip_device_enumeration] ERROR");
    end
    $finish;
  end

endmodule
